>>> rtl/slspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspd_pkg
// Shared constants and controller/datapath interface types for the
// sync/length/checksum packet deframer.
// ----------------------------------------------------------------------------
package slspd_pkg;

    localparam int            MAX_PAYLOAD_DEF = 32;
    localparam int            OVERHEAD        = 6;
    localparam logic [7:0]    SYNC_A          = 8'hFF;
    localparam logic [7:0]    SYNC_B          = 8'h55;

    typedef struct packed {
        logic wr;
        logic drop_one;
        logic drop_pkt;
        logic rd_first;
        logic rd_inc;
        logic rd_pay;
        logic sum_load;
        logic sum_add;
        logic cmd_load;
        logic len_load;
        logic chk_load;
        logic out_load;
        logic out_has;
    } slspd_cmd_t;

    typedef struct packed {
        logic cnt_ge6;
        logic sync_a_ok;
        logic sync_b_ok;
        logic len_bad;
        logic need_more;
        logic off_pay;
        logic off_hi;
        logic sum_ok;
        logic len_zero;
        logic last_pay;
        logic out_free;
    } slspd_sts_t;

endpackage

>>> rtl/slspd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspd_datapath
// Circular byte window, header/checksum registers and result register.
// ----------------------------------------------------------------------------
module slspd_datapath
    import slspd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  slspd_cmd_t cmd,
    output slspd_sts_t sts,
    output logic       pkt_valid,
    input  logic       pkt_ready,
    output logic [7:0] command,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic [4:0] byte_index,
    output logic       last
);

    localparam int DEPTH = MAX_PAYLOAD + OVERHEAD;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W:0] DEPTH_X = (PTR_W + 1)'(DEPTH);

    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] s);
        logic [PTR_W:0] t;
        t = (s >= DEPTH_X) ? s - DEPTH_X : s;
        return t[PTR_W-1:0];
    endfunction

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] off_reg, off_next;
    logic [15:0]      sum_reg;
    logic [7:0]       cmd_reg;
    logic [7:0]       len_reg;
    logic [7:0]       chk_hi_reg;
    logic             out_valid_reg;
    logic [7:0]       command_reg;
    logic [7:0]       data_reg;
    logic             has_reg;
    logic [4:0]       index_reg;
    logic             last_reg;

    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic             rd_en;
    logic [PTR_W:0]   pkt_len;
    logic [7:0]       idx_full;

    assign rd_en   = cmd.rd_first | cmd.rd_inc | cmd.rd_pay;
    assign pkt_len = (PTR_W + 1)'(len_reg) + (PTR_W + 1)'(OVERHEAD);
    assign wr_addr = wrap_ptr((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(count_reg));
    assign rd_addr = wrap_ptr((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(off_next));
    assign idx_full = 8'(off_reg) - 8'd4;

    always_comb
    begin
        case (1'b1)
            cmd.rd_first: off_next = '0;
            cmd.rd_inc:   off_next = off_reg + PTR_W'(1);
            cmd.rd_pay:   off_next = PTR_W'(4);
            default:      off_next = off_reg;
        endcase
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.wr)
        begin
            if (count_reg == CNT_W'(DEPTH))
                head_next = wrap_ptr((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(1));
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.drop_one)
        begin
            head_next  = wrap_ptr((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(1));
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.drop_pkt)
        begin
            head_next  = wrap_ptr((PTR_W + 1)'(head_reg) + pkt_len);
            count_next = count_reg - CNT_W'(len_reg) - CNT_W'(OVERHEAD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[wr_addr] <= rx_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            off_reg   <= off_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (pkt_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
            sum_reg <= 16'(rd_data_reg);
        else if (cmd.sum_add)
            sum_reg <= sum_reg + 16'(rd_data_reg);
        if (cmd.cmd_load)
            cmd_reg <= rd_data_reg;
        if (cmd.len_load)
            len_reg <= rd_data_reg;
        if (cmd.chk_load)
            chk_hi_reg <= rd_data_reg;
        if (cmd.out_load)
        begin
            command_reg <= cmd_reg;
            has_reg     <= cmd.out_has;
            data_reg    <= cmd.out_has ? rd_data_reg : 8'd0;
            index_reg   <= cmd.out_has ? idx_full[4:0] : 5'd0;
            last_reg    <= cmd.out_has ? sts.last_pay : 1'b1;
        end
    end

    assign sts.cnt_ge6   = count_reg >= CNT_W'(OVERHEAD);
    assign sts.sync_a_ok = rd_data_reg == SYNC_A;
    assign sts.sync_b_ok = rd_data_reg == SYNC_B;
    assign sts.len_bad   = rd_data_reg > 8'(MAX_PAYLOAD);
    assign sts.need_more = 9'(count_reg) < 9'(rd_data_reg) + 9'(OVERHEAD);
    assign sts.off_pay   = 9'(off_reg) < 9'(len_reg) + 9'd4;
    assign sts.off_hi    = 9'(off_reg) == 9'(len_reg) + 9'd4;
    assign sts.sum_ok    = sum_reg == {chk_hi_reg, rd_data_reg};
    assign sts.len_zero  = len_reg == 8'd0;
    assign sts.last_pay  = 9'(off_reg) == 9'(len_reg) + 9'd3;
    assign sts.out_free  = !out_valid_reg || pkt_ready;

    assign pkt_valid  = out_valid_reg;
    assign command    = command_reg;
    assign data_byte  = data_reg;
    assign has_data   = has_reg;
    assign byte_index = index_reg;
    assign last       = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("window count exceeds depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < PTR_W'(DEPTH))
        else $error("head pointer out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || pkt_ready))
        else $error("result register overwritten");

    a_drop_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_pkt |-> (9'(count_reg) >= 9'(len_reg) + 9'(OVERHEAD)))
        else $error("packet drop larger than window");

endmodule

>>> rtl/slspd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slspd_ctrl
// Scan sequencer: header check, checksum pass, result emission, drops.
// ----------------------------------------------------------------------------
module slspd_ctrl
    import slspd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  slspd_sts_t sts,
    output slspd_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_SUM,
        S_EMIT,
        S_EMPTY
    } state_t;

    state_t state_reg, state_next;
    logic   rx_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.wr     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.cnt_ge6)
                    state_next = S_IDLE;
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_H0;
                end
            end
            S_H0:
            begin
                if (!sts.sync_a_ok)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_CHECK;
                end
                else
                begin
                    cmd.sum_load = 1'b1;
                    cmd.rd_inc   = 1'b1;
                    state_next   = S_H1;
                end
            end
            S_H1:
            begin
                if (!sts.sync_b_ok)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_CHECK;
                end
                else
                begin
                    cmd.sum_add = 1'b1;
                    cmd.rd_inc  = 1'b1;
                    state_next  = S_H2;
                end
            end
            S_H2:
            begin
                cmd.cmd_load = 1'b1;
                cmd.sum_add  = 1'b1;
                cmd.rd_inc   = 1'b1;
                state_next   = S_H3;
            end
            S_H3:
            begin
                if (sts.len_bad)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_CHECK;
                end
                else if (sts.need_more)
                    state_next = S_IDLE;
                else
                begin
                    cmd.len_load = 1'b1;
                    cmd.sum_add  = 1'b1;
                    cmd.rd_inc   = 1'b1;
                    state_next   = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sts.off_pay)
                begin
                    cmd.sum_add = 1'b1;
                    cmd.rd_inc  = 1'b1;
                end
                else if (sts.off_hi)
                begin
                    cmd.chk_load = 1'b1;
                    cmd.rd_inc   = 1'b1;
                end
                else if (!sts.sum_ok)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_CHECK;
                end
                else if (sts.len_zero)
                    state_next = S_EMPTY;
                else
                begin
                    cmd.rd_pay = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_has  = 1'b1;
                    if (sts.last_pay)
                    begin
                        cmd.drop_pkt = 1'b1;
                        state_next   = S_CHECK;
                    end
                    else
                        cmd.rd_inc = 1'b1;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.drop_pkt = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rx_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            rx_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign rx_ready = rx_ready_reg;

    a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> rx_ready)
        else $error("window write outside idle");

    a_one_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.wr, cmd.drop_one, cmd.drop_pkt}) <= 1)
        else $error("conflicting window updates");

    a_scan_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |=> (state_reg == S_CHECK))
        else $error("scan not started after write");

endmodule

>>> rtl/sync_length_sum_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_packet_deframer
// Finds FF 55 / command / length / payload / 16-bit sum packets in a byte
// stream and emits one result per payload byte (one without data if empty).
//
//   channel | direction | handshake          | payload
//   rx      | in        | rx_valid/rx_ready  | rx_byte
//   pkt     | out       | pkt_valid/pkt_ready| command, data_byte, has_data,
//           |           |                    | byte_index, last
//
// After a full packet check, results follow at one per cycle while pkt_ready
// is high. Each dropped byte restarts the scan; the window memory's single
// registered read port sets the pace of the scan.
// Reset empties the window at once; pkt_ready low stalls result emission.
// ----------------------------------------------------------------------------
module sync_length_sum_packet_deframer
    import slspd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       pkt_valid,
    input  logic       pkt_ready,
    output logic [7:0] command,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic [4:0] byte_index,
    output logic       last
);

    slspd_cmd_t cmd;
    slspd_sts_t sts;

    slspd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slspd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .command    (command),
        .data_byte  (data_byte),
        .has_data   (has_data),
        .byte_index (byte_index),
        .last       (last)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length/checksum packet deframer. A short
// table of hand-built frames (empty payloads, a checksum mismatch, an
// oversized length, a one-byte payload) is followed by random traffic: mostly
// well-formed frames with random content, plus corrupted, truncated and
// oversized frames and loose noise bytes. A behavioral deframer tracks the
// byte window and queues the results each accepted byte releases; every
// result transaction is compared field by field against that queue.
// ----------------------------------------------------------------------------
module tb_top;
    import slspd_pkg::*;

    localparam int WIN_DEPTH    = MAX_PAYLOAD_DEF + OVERHEAD;
    localparam int RANDOM_ITEMS = 125;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] data_byte;
        logic       has_data;
        logic [4:0] byte_index;
        logic       last;
    } pkt_res_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        pkt_res_t   res;
    } stim_row_t;

    localparam pkt_res_t NO_RES = '0;

    logic       clk;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       pkt_valid;
    logic       pkt_ready;
    logic [7:0] command;
    logic [7:0] data_byte;
    logic       has_data;
    logic [4:0] byte_index;
    logic       last;

    logic [7:0] rx_window [0:WIN_DEPTH-1];
    int         held;
    pkt_res_t   fresh [$];
    pkt_res_t   expected_pkts [$];
    int         errors;
    int         sent;
    bit         tx_quiet;
    bit         rx_calm;

    sync_length_sum_packet_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .command   (command),
        .data_byte (data_byte),
        .has_data  (has_data),
        .byte_index(byte_index),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic shift_out(input int k);
        int i;
        if (k >= held)
        begin
            held = 0;
        end
        else
        begin
            for (i = 0; i < held - k; i++)
                rx_window[i] = rx_window[i + k];
            held -= k;
        end
    endtask

    // Append one byte to the window and collect every packet it completes.
    task automatic deframe_byte(input logic [7:0] b);
        int          i;
        int          len;
        int          n;
        logic [15:0] sum;
        logic [15:0] want;
        fresh.delete();
        if (held >= WIN_DEPTH)
            shift_out(1);
        rx_window[held] = b;
        held++;
        while (held >= OVERHEAD)
        begin
            if (rx_window[0] != SYNC_A || rx_window[1] != SYNC_B ||
                rx_window[3] > MAX_PAYLOAD_DEF)
            begin
                shift_out(1);
                continue;
            end
            len = rx_window[3];
            n   = len + OVERHEAD;
            if (held < n)
                break;
            sum = '0;
            for (i = 0; i < n - 2; i++)
                sum = sum + 16'(rx_window[i]);
            want = {rx_window[n - 2], rx_window[n - 1]};
            if (sum != want)
            begin
                shift_out(1);
                continue;
            end
            if (len == 0)
            begin
                if (fresh.size() < MAX_PAYLOAD_DEF)
                    fresh.insert(fresh.size(), '{rx_window[2], 8'h00, 1'b0, 5'd0, 1'b1});
            end
            else
            begin
                for (i = 0; i < len; i++)
                    if (fresh.size() < MAX_PAYLOAD_DEF)
                        fresh.insert(fresh.size(), '{rx_window[2], rx_window[4 + i],
                                     1'b1, 5'(i), 1'(i == len - 1)});
            end
            shift_out(n);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pkt_valid === 1'b1 && pkt_ready === 1'b1)
        begin
            if (expected_pkts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, {command, data_byte, has_data, byte_index, last});
                errors++;
            end
            else
            begin
                check_field("command", expected_pkts[0].command, command);
                check_field("data_byte", expected_pkts[0].data_byte, data_byte);
                check_field("has_data", expected_pkts[0].has_data, has_data);
                check_field("byte_index", expected_pkts[0].byte_index, byte_index);
                check_field("last", expected_pkts[0].last, last);
                void'(expected_pkts.pop_front());
            end
        end
    end

    // Hold the sender for a random gap, then present the byte until accepted.
    task automatic send_byte(input logic [7:0] b, input bit typed, input pkt_res_t res);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk) rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_ready !== 1'b1);
        deframe_byte(b);
        if (typed)
            expected_pkts.insert(expected_pkts.size(), res);
        else
            foreach (fresh[i])
                expected_pkts.insert(expected_pkts.size(), fresh[i]);
        sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk) rx_valid <= 1'b0;
        while (expected_pkts.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return SYNC_A;
            1:       return SYNC_B;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 8);
        else if (r == 7)
            return MAX_PAYLOAD_DEF;
        else
            return $urandom_range(9, MAX_PAYLOAD_DEF - 1);
    endfunction

    // Build a frame; cut < 0 sends it whole, spoil flips one bit past the sync.
    task automatic send_frame(input logic [7:0] cmd, input int len, input int cut,
                              input bit spoil);
        logic [7:0]  frame [$];
        logic [15:0] sum;
        int          i;
        int          pos;
        frame = {SYNC_A, SYNC_B, cmd, 8'(len)};
        for (i = 0; i < len && i < 255; i++)
            frame.insert(frame.size(), pick_byte());
        sum = '0;
        foreach (frame[j])
            sum = sum + 16'(frame[j]);
        frame.insert(frame.size(), sum[15:8]);
        frame.insert(frame.size(), sum[7:0]);
        if (spoil)
        begin
            pos = $urandom_range(2, frame.size() - 1);
            frame[pos] = frame[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (cut >= 0 && cut < frame.size())
            frame = frame[0:cut - 1];
        foreach (frame[j])
            send_byte(frame[j], 1'b0, NO_RES);
    endtask

    initial
    begin
        stim_row_t directed_rows [29];
        int        kind;
        int        len;
        bit        paused;
        directed_rows = '{
            '{8'hFF, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES}, '{8'hA5, 1'b0, NO_RES},
            '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
            '{8'hF9, 1'b1, '{8'hA5, 8'h00, 1'b0, 5'd0, 1'b1}},
            '{8'hFF, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
            '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES},
            '{8'hFF, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
            '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
            '{8'h54, 1'b1, '{8'h00, 8'h00, 1'b0, 5'd0, 1'b1}},
            '{8'hFF, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES}, '{8'h7E, 1'b0, NO_RES},
            '{8'h21, 1'b0, NO_RES},
            '{8'hFF, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES}, '{8'h3C, 1'b0, NO_RES},
            '{8'h01, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES},
            '{8'h11, 1'b0, NO_RES}
        };
        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = 8'h00;
        held     = 0;
        errors   = 0;
        sent     = 0;
        tx_quiet = 1'b0;
        paused   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
        hold_until_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 99);
            if (kind < 55)
                send_frame(8'($urandom()), pick_len(), -1, 1'b0);
            else if (kind < 67)
                send_frame(8'($urandom()), pick_len(), -1, 1'b1);
            else if (kind < 75)
                send_frame(8'($urandom()), $urandom_range(MAX_PAYLOAD_DEF + 1, 255),
                           4 + $urandom_range(0, 3), 1'b0);
            else if (kind < 85)
            begin
                len = pick_len();
                send_frame(8'($urandom()), len, $urandom_range(4, len + 5), 1'b0);
            end
            else
                repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0, NO_RES);
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        @(negedge clk) rx_valid <= 1'b0;
        while (expected_pkts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_pkts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int hold_n;
        pkt_ready = 1'b0;
        rx_calm   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            hold_n = rx_calm ? 0 : $urandom_range(0, 5);
            repeat (hold_n) @(negedge clk) pkt_ready <= 1'b0;
            @(negedge clk) pkt_ready <= 1'b1;
            do @(posedge clk); while (pkt_valid !== 1'b1);
        end
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/slspd_pkg.sv
rtl/slspd_datapath.sv
rtl/slspd_ctrl.sv
rtl/sync_length_sum_packet_deframer.sv
test/tb_top.sv
